// ----- hdl/led_mode_override_stack_assert.svh -----
// Assertion macros shared by the LED mode override stack RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef LED_MODE_OVERRIDE_STACK_ASSERT_SVH
`define LED_MODE_OVERRIDE_STACK_ASSERT_SVH

// Same-cycle implication.
`define LMOS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LMOS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lmos_pkg.sv -----
package lmos_pkg;

  // Default stack depth
  localparam int STACK_DEPTH_DEF = 8;

  // Field widths
  localparam int RemW   = 16;
  localparam int CountW = 4;

  // Mode codes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_SLOW = 2'd2;
  localparam logic [1:0] MODE_FAST = 2'd3;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_SLOW_HALF = 2'd0;
  localparam logic [1:0] REG_FAST_HALF = 2'd1;
  localparam logic [1:0] REG_TICKS_UNIT = 2'd2;

  // Register reset values
  localparam logic [7:0] SLOW_HALF_RESET  = 8'd10;
  localparam logic [7:0] FAST_HALF_RESET  = 8'd2;
  localparam logic [7:0] TICKS_UNIT_RESET = 8'd10;

  typedef struct packed {
    logic       operation;
    logic [1:0] mode;
    logic [7:0] duration;
  } req_t;

  typedef struct packed {
    logic              led_level;
    logic [1:0]        active_mode;
    logic              sequencing;
    logic              push_rejected;
    logic [CountW-1:0] override_count;
  } rsp_t;

  // One override on the stack
  typedef struct packed {
    logic [1:0]      mode;
    logic [RemW-1:0] remaining;
  } entry_t;

endpackage

// ----- hdl/lmos_ram.sv -----
module lmos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/led_mode_override_stack.sv -----
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_write             cfg_index, cfg_data
// req       in         req_valid/req_ready   req (req_t)
// rsp       out        rsp_valid/rsp_ready   rsp (rsp_t)
//
// A set request, a rejected push and a tick that touches no override finish on acceptance.
// A tick with live overrides walks the stack: the stack RAM is read once per
// entry, and survivors are written back compacted through its single write port.
// Reset clears control state; the stack RAM is not cleared, the fill count marks
// which entries are live. A result waits in an output register with a one-item
// skid behind it; req_ready drops only while a tick walks the stack or the skid is full.
`include "led_mode_override_stack_assert.svh"

module led_mode_override_stack import lmos_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp
);

  localparam int IdxW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FillW = $clog2(STACK_DEPTH + 1);
  localparam int EntW  = $bits(entry_t);
  localparam logic [FillW-1:0] FullCount = FillW'(STACK_DEPTH);

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t           state, state_next;
  logic [7:0]       slow_half, fast_half, ticks_unit;
  logic [1:0]       base_mode, base_mode_next;
  logic [1:0]       top_mode, top_mode_next;
  logic [FillW-1:0] fill, fill_next;
  logic [8:0]       phase, phase_next;
  logic             lamp, lamp_next;
  logic             ticking, ticking_next;
  logic [IdxW-1:0]  rd_idx, rd_idx_next;
  logic [FillW-1:0] wr_cnt, wr_cnt_next;
  logic             removed, removed_next;
  logic             skid_valid;
  rsp_t             skid;

  logic             accept;
  logic             fin;
  rsp_t             res;
  logic [1:0]       mode_now;
  logic             blink;
  logic [7:0]       half_raw, half;
  logic [8:0]       phase_wrap;
  logic             pattern_lamp;
  logic [7:0]       tpu_eff;
  logic [RemW-1:0]  product;
  entry_t           ent;
  logic [RemW-1:0]  dec;
  logic             keep;
  logic             last;

  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [EntW-1:0]  ram_wdata, ram_rdata;

  lmos_ram #(
    .WIDTH (EntW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_ready = (state == S_IDLE) && !skid_valid;
  assign accept    = req_valid && req_ready;

  // Evaluate the pattern of the mode in force; only blink modes wrap the phase
  assign mode_now     = (fill != '0) ? top_mode : base_mode;
  assign blink        = (mode_now == MODE_SLOW) || (mode_now == MODE_FAST);
  assign half_raw     = (mode_now == MODE_SLOW) ? slow_half : fast_half;
  assign half         = (half_raw == 8'd0) ? 8'd1 : half_raw;
  assign phase_wrap   = (blink && (phase >= {half, 1'b0})) ? 9'd0 : phase;
  assign pattern_lamp = (mode_now == MODE_ON) ||
                        (blink && (phase_wrap >= {1'b0, half}));

  // Scale the override length
  assign tpu_eff = (ticks_unit == 8'd0) ? 8'd1 : ticks_unit;
  assign product = {8'd0, req.duration} * {8'd0, tpu_eff};

  // Count down the entry read back from the stack
  assign ent  = ram_rdata;
  assign dec  = (ent.remaining != '0) ? ent.remaining - RemW'(1) : '0;
  assign keep = (dec != '0);
  assign last = (FillW'(rd_idx) + FillW'(1)) == fill;

  // Sequence set requests, pushes and ticks
  always_comb begin
    state_next     = state;
    base_mode_next = base_mode;
    top_mode_next  = top_mode;
    fill_next      = fill;
    phase_next     = phase;
    lamp_next      = lamp;
    ticking_next   = ticking;
    rd_idx_next    = rd_idx;
    wr_cnt_next    = wr_cnt;
    removed_next   = removed;
    fin            = 1'b0;
    res            = '0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          fin = 1'b1;
          if (req.operation == OP_TICK) begin
            if (ticking) begin
              if (fill == '0 && !blink) begin
                lamp_next    = (mode_now == MODE_ON);
                ticking_next = 1'b0;
              end else if (fill == '0) begin
                lamp_next  = pattern_lamp;
                phase_next = phase_wrap + 9'd1;
              end else begin
                // Walk the stack from the bottom
                fin          = 1'b0;
                lamp_next    = pattern_lamp;
                phase_next   = phase_wrap;
                rd_idx_next  = '0;
                wr_cnt_next  = '0;
                removed_next = 1'b0;
                ram_re       = 1'b1;
                state_next   = S_WALK;
              end
            end
          end else if (req.duration == 8'd0) begin
            base_mode_next = req.mode;
            if (!ticking) begin
              if (req.mode == MODE_ON) begin
                lamp_next = 1'b1;
              end else if (req.mode == MODE_OFF) begin
                lamp_next = 1'b0;
              end else begin
                ticking_next = 1'b1;
                phase_next   = '0;
              end
            end
          end else if (fill == FullCount) begin
            res.push_rejected = 1'b1;
          end else begin
            ram_we        = 1'b1;
            ram_waddr     = fill[IdxW-1:0];
            ram_wdata     = {req.mode, product};
            fill_next     = fill + FillW'(1);
            top_mode_next = req.mode;
            if (!ticking) begin
              ticking_next = 1'b1;
              phase_next   = '0;
            end
          end
        end
      end
      S_WALK: begin
        // Write back survivors compacted, drop expired entries
        if (keep) begin
          ram_we        = 1'b1;
          ram_waddr     = wr_cnt[IdxW-1:0];
          ram_wdata     = {ent.mode, dec};
          top_mode_next = ent.mode;
        end
        wr_cnt_next  = wr_cnt + FillW'(keep);
        removed_next = removed || !keep;
        if (last) begin
          fin        = 1'b1;
          fill_next  = wr_cnt_next;
          phase_next = removed_next ? 9'd0 : phase + 9'd1;
          state_next = S_IDLE;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = rd_idx + IdxW'(1);
          rd_idx_next = rd_idx + IdxW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.led_level      = lamp_next;
    res.active_mode    = (fill_next != '0) ? top_mode_next : base_mode_next;
    res.sequencing     = ticking_next;
    res.override_count = CountW'(fill_next);
  end

  // Hold state, configuration and the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slow_half  <= SLOW_HALF_RESET;
      fast_half  <= FAST_HALF_RESET;
      ticks_unit <= TICKS_UNIT_RESET;
      base_mode  <= MODE_OFF;
      fill       <= '0;
      phase      <= '0;
      lamp       <= 1'b0;
      ticking    <= 1'b0;
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      state     <= state_next;
      base_mode <= base_mode_next;
      fill      <= fill_next;
      phase     <= phase_next;
      lamp      <= lamp_next;
      ticking   <= ticking_next;

      if (cfg_write) begin
        case (cfg_index)
          REG_SLOW_HALF:  slow_half  <= cfg_data;
          REG_FAST_HALF:  fast_half  <= cfg_data;
          REG_TICKS_UNIT: ticks_unit <= cfg_data;
          default: ;
        endcase
      end

      // Advance the output register, park a result in the skid when stalled
      if (!rsp_valid || rsp_ready) begin
        if (skid_valid) begin
          rsp        <= skid;
          rsp_valid  <= 1'b1;
          skid_valid <= fin;
          if (fin) begin
            skid <= res;
          end
        end else begin
          rsp_valid <= fin;
          if (fin) begin
            rsp <= res;
          end
        end
      end else if (fin) begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  // Stack-top and walk registers need no reset
  always_ff @(posedge clk) begin
    top_mode <= top_mode_next;
    rd_idx   <= rd_idx_next;
    wr_cnt   <= wr_cnt_next;
    removed  <= removed_next;
  end

  `LMOS_CHECK(walk_write_trails_read, (state == S_WALK) && ram_we, FillW'(ram_waddr) <= FillW'(rd_idx), "write-back overtook the read pointer")
  `LMOS_CHECK(skid_behind_output, skid_valid, rsp_valid, "skid holds an item while the output is empty")
  `LMOS_CHECK(idle_stack_empty, !ticking, fill == '0, "overrides live while ticks are idle")
  `LMOS_CHECK(reject_only_when_full, fin && res.push_rejected, fill == FullCount, "push rejected below full stack")
  `LMOS_NEXT(push_grows_stack, accept && (req.operation == OP_SET) && (req.duration != 8'd0) && (fill != FullCount), fill == $past(fill) + FillW'(1), "accepted push did not grow the stack")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import lmos_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp;

  led_mode_override_stack i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the lamp sequencer
  logic [7:0]  slow_half = SLOW_HALF_RESET;
  logic [7:0]  fast_half = FAST_HALF_RESET;
  logic [7:0]  unit_ticks = TICKS_UNIT_RESET;
  logic [1:0]  lamp_base = MODE_OFF;
  logic [1:0]  ovr_mode [STACK_DEPTH_DEF];
  logic [15:0] ovr_left [STACK_DEPTH_DEF];
  logic [3:0]  ovr_fill = '0;
  logic [8:0]  blink_phase = '0;
  logic        lamp_on = 1'b0;
  logic        seq_on = 1'b0;

  req_t req_queue [$];
  rsp_t rsp_due [$];
  int   queued_count = 0;
  int   taken_count = 0;
  int   err_count = 0;
  int   n_tick = 0, n_base = 0, n_push = 0, n_refused = 0, n_expired = 0;
  int   send_idle = 31;
  int   recv_idle = 85;
  int   calm = 0;
  logic req_taken = 1'b0;

  function automatic logic [1:0] mode_now();
    return (ovr_fill > 0) ? ovr_mode[ovr_fill - 1] : lamp_base;
  endfunction

  // Apply one accepted item to the shadow state and return its result
  task automatic step_lamp(input req_t it, output rsp_t r);
    logic        refused;
    logic [1:0]  m;
    logic [15:0] rem;
    logic [7:0]  half;
    logic [7:0]  unit;
    int          rd, wr, h;
    bit          dropped;
    refused = 1'b0;
    if (it.operation == OP_TICK) begin
      n_tick++;
      m = mode_now();
      if (!seq_on) begin
        // idle tick: nothing moves
      end else if (ovr_fill == 0 && (m == MODE_OFF || m == MODE_ON)) begin
        // steady base left: settle the lamp and stop sequencing
        lamp_on = (m == MODE_ON);
        seq_on = 1'b0;
      end else begin
        if (m == MODE_OFF) begin
          lamp_on = 1'b0;
        end else if (m == MODE_ON) begin
          lamp_on = 1'b1;
        end else begin
          half = (m == MODE_SLOW) ? slow_half : fast_half;
          h = (half == 0) ? 1 : int'(half);
          if (int'(blink_phase) >= 2 * h) blink_phase = '0;
          lamp_on = (int'(blink_phase) >= h);
        end
        // count down every override, compact out the expired ones
        wr = 0;
        dropped = 1'b0;
        for (rd = 0; rd < int'(ovr_fill); rd++) begin
          rem = ovr_left[rd];
          if (rem > 0) rem--;
          if (rem == 0) begin
            dropped = 1'b1;
            n_expired++;
          end else begin
            ovr_mode[wr] = ovr_mode[rd];
            ovr_left[wr] = rem;
            wr++;
          end
        end
        ovr_fill = 4'(wr);
        blink_phase = dropped ? 9'd0 : blink_phase + 9'd1;
      end
    end else if (it.duration == 8'd0) begin
      n_base++;
      lamp_base = it.mode;
      if (!seq_on) begin
        if (it.mode == MODE_ON) begin
          lamp_on = 1'b1;
        end else if (it.mode == MODE_OFF) begin
          lamp_on = 1'b0;
        end else begin
          seq_on = 1'b1;
          blink_phase = '0;
        end
      end
    end else if (ovr_fill >= STACK_DEPTH_DEF) begin
      refused = 1'b1;
      n_refused++;
    end else begin
      n_push++;
      unit = (unit_ticks == 0) ? 8'd1 : unit_ticks;
      ovr_mode[ovr_fill] = it.mode;
      ovr_left[ovr_fill] = 16'(it.duration) * 16'(unit);
      ovr_fill++;
      if (!seq_on) begin
        seq_on = 1'b1;
        blink_phase = '0;
      end
    end
    r.led_level = lamp_on;
    r.active_mode = mode_now();
    r.sequencing = seq_on;
    r.push_rejected = refused;
    r.override_count = ovr_fill;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= 40)
      $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  // Drive items at the falling edge; hold an item until it is taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      req_valid <= 1'b1;
    end else if (req_queue.size() > 0 && (calm > 0 || $urandom_range(99) >= send_idle)) begin
      req_valid <= 1'b1;
      req <= req_queue.pop_front();
    end else begin
      req_valid <= 1'b0;
    end
  end

  // Stall the result side at random, with calm stretches on both sides
  always @(negedge clk) begin
    if (calm > 0) calm <= calm - 1;
    else if ($urandom_range(63) == 0) calm <= $urandom_range(16, 64);
    rsp_ready <= !rst && (calm > 0 || $urandom_range(99) >= recv_idle);
  end

  // Predict on each accepted item, check each accepted result
  always @(posedge clk) begin : watch_ports
    rsp_t due;
    rsp_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && req_ready;
      if (req_valid && req_ready) begin
        step_lamp(req, due);
        rsp_due.push_back(due);
        taken_count++;
      end
      if (rsp_valid && rsp_ready) begin
        if (rsp_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", 1, 0);
        end else begin
          want = rsp_due.pop_front();
          if (rsp.led_level !== want.led_level)
            report_mismatch("led_level", rsp.led_level, want.led_level);
          if (rsp.active_mode !== want.active_mode)
            report_mismatch("active_mode", rsp.active_mode, want.active_mode);
          if (rsp.sequencing !== want.sequencing)
            report_mismatch("sequencing", rsp.sequencing, want.sequencing);
          if (rsp.push_rejected !== want.push_rejected)
            report_mismatch("push_rejected", rsp.push_rejected, want.push_rejected);
          if (rsp.override_count !== want.override_count)
            report_mismatch("override_count", rsp.override_count, want.override_count);
        end
      end
    end
  end

  task automatic add_item(input logic op, input logic [1:0] m, input logic [7:0] dur);
    req_t it;
    it.operation = op;
    it.mode = m;
    it.duration = dur;
    req_queue.push_back(it);
    queued_count++;
  endtask

  // Mostly ticks and short overrides, with bursts that fill the stack
  task automatic queue_random(input int count);
    int i, k, pick;
    i = 0;
    while (i < count) begin
      if ($urandom_range(19) == 0) begin
        for (k = $urandom_range(8, 10); k > 0; k--) begin
          add_item(OP_SET, 2'($urandom_range(3)), 8'($urandom_range(1, 3)));
          i++;
        end
      end else begin
        pick = $urandom_range(99);
        if (pick < 58)
          add_item(OP_TICK, 2'($urandom_range(3)), 8'($urandom_range(255)));
        else if (pick < 72)
          add_item(OP_SET, 2'($urandom_range(3)), 8'd0);
        else if ($urandom_range(3) != 0)
          add_item(OP_SET, 2'($urandom_range(3)), 8'($urandom_range(1, 3)));
        else
          add_item(OP_SET, 2'($urandom_range(3)), 8'($urandom_range(1, 255)));
        i++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (taken_count != queued_count || rsp_due.size() != 0);
  endtask

  // Write one register while the block is idle and mirror it
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_SLOW_HALF:  slow_half = val;
      REG_FAST_HALF:  fast_half = val;
      REG_TICKS_UNIT: unit_ticks = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    int seg;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (seg = 0; seg < 4; seg++) begin
      if (seg > 0) begin
        // let any stack walk finish before touching the registers
        wait_drained();
        repeat (20) @(negedge clk);
        case (seg)
          1: begin
            write_reg(REG_SLOW_HALF, 8'd1);
            write_reg(REG_FAST_HALF, 8'd1);
            write_reg(REG_TICKS_UNIT, 8'd1);
          end
          2: begin
            write_reg(REG_SLOW_HALF, 8'd255);
            write_reg(REG_FAST_HALF, 8'd255);
            write_reg(REG_TICKS_UNIT, 8'd255);
          end
          default: begin
            write_reg(REG_SLOW_HALF, 8'($urandom_range(1, 255)));
            write_reg(REG_FAST_HALF, 8'($urandom_range(1, 12)));
            write_reg(REG_TICKS_UNIT, 8'($urandom_range(1, 6)));
          end
        endcase
      end
      send_idle = (seg == 0) ? 31 : (seg == 1) ? 85 : 0;
      recv_idle = (seg == 0) ? 85 : (seg == 1) ? 31 : 0;

      if (seg == 0) begin
        // idle tick, base changes while idle and while sequencing
        add_item(OP_TICK, MODE_FAST, 8'd255);
        add_item(OP_SET, MODE_ON, 8'd0);
        add_item(OP_SET, MODE_OFF, 8'd0);
        add_item(OP_SET, MODE_SLOW, 8'd0);
        add_item(OP_TICK, MODE_OFF, 8'd0);
        add_item(OP_TICK, MODE_ON, 8'd1);
        add_item(OP_SET, MODE_FAST, 8'd0);
        add_item(OP_TICK, MODE_OFF, 8'd0);
        add_item(OP_SET, MODE_ON, 8'd0);
        add_item(OP_TICK, MODE_OFF, 8'd0);
        // fill the stack with every mode, then push onto a full stack
        add_item(OP_SET, MODE_OFF, 8'd1);
        add_item(OP_SET, MODE_ON, 8'd255);
        add_item(OP_SET, MODE_SLOW, 8'd2);
        add_item(OP_SET, MODE_FAST, 8'd1);
        add_item(OP_SET, MODE_OFF, 8'd255);
        add_item(OP_SET, MODE_ON, 8'd3);
        add_item(OP_SET, MODE_SLOW, 8'd1);
        add_item(OP_SET, MODE_FAST, 8'd128);
        add_item(OP_SET, MODE_SLOW, 8'd7);
        add_item(OP_TICK, MODE_OFF, 8'd0);
        add_item(OP_TICK, MODE_OFF, 8'd0);
        add_item(OP_SET, MODE_FAST, 8'd0);
        queue_random(240);
      end else begin
        queue_random(265);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (rsp_due.size() != 0) report_mismatch("results never delivered", 0, rsp_due.size());

    $display("tb: ran %0d items over 4 register settings: %0d ticks, %0d base sets,",
             taken_count, n_tick, n_base);
    $display("tb: %0d pushes, %0d refused on a full stack, %0d overrides expired",
             n_push, n_refused, n_expired);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
